// File: hw/rtl/mbts_pkg.sv
// Shared types, constants and fixed-point helpers for the backprop training unit.
`default_nettype none
package mbts_pkg;

  typedef logic signed [23:0] q_t;
  typedef logic [16:0] uq_t;

  typedef enum logic [1:0] {
    KIND_TRAIN = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam q_t Q_ONE    = 24'sd65536;
  localparam q_t Q_MAX    = 24'sd8388607;
  localparam q_t Q_MIN    = -24'sd8388608;
  localparam q_t SIG_SPAN = 24'sd524288;

  function automatic q_t sat24(input logic signed [48:0] v);
    if (v > 49'sd8388607) return Q_MAX;
    if (v < -49'sd8388608) return Q_MIN;
    return v[23:0];
  endfunction

  // Unsigned long division by shift and subtract, used only to build the table.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table entry i of n, evaluated while the design elaborates.
  function automatic uq_t sigmoid_entry(input int unsigned i, input int unsigned n);
    longint xq;
    longint unsigned t, u, one, sum, term, em, den, res;
    xq = longint'(udiv64(64'(i) << 34, 64'(n))) - (longint'(1) << 33);
    t = (xq < 0) ? longint'(-xq) : longint'(xq);
    u = t >> 4;
    one = 64'd1 << 30;
    sum = one;
    term = one;
    for (int k = 1; k < 20; k++) begin
      term = (term * u) >> 30;
      term = udiv64(term, 64'(k));
      sum = sum + term;
    end
    em = udiv64((64'd1 << 60) + (sum >> 1), sum);
    for (int r = 0; r < 4; r++) em = (em * em + (one >> 1)) >> 30;
    den = one + em;
    if (xq >= 0) res = udiv64((64'd1 << 46) + (den >> 1), den);
    else res = udiv64((em << 16) + (den >> 1), den);
    return res[16:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mbts_in_if.sv
// Input channel: one training, load or readback request per word.
`default_nettype none
interface mbts_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  mbts_pkg::q_t     feature_a;
  mbts_pkg::q_t     feature_b;
  mbts_pkg::uq_t    target;
  logic [3:0]       weight_index;
  mbts_pkg::q_t     weight_value;
  modport source (output valid, kind, feature_a, feature_b, target, weight_index,
                  weight_value, input ready);
  modport sink (input valid, kind, feature_a, feature_b, target, weight_index,
                weight_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mbts_out_if.sv
// Result channel: prediction and readback per word.
`default_nettype none
interface mbts_out_if;
  logic          valid;
  logic          ready;
  mbts_pkg::uq_t prediction;
  mbts_pkg::q_t  readback;
  modport source (output valid, prediction, readback, input ready);
  modport sink (input valid, prediction, readback, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mbts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mbts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/mbts_sig_rom.sv
// Sigmoid lookup ROM over -8..8 with registered read data.
`default_nettype none
module mbts_sig_rom #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(ENTRIES)-1:0] addr,
  output mbts_pkg::uq_t                   data_r
);
  typedef mbts_pkg::uq_t rom_t [ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ENTRIES; i++) r[i] = mbts_pkg::sigmoid_entry(i, ENTRIES);
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    data_r <= ROM[addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/mbts_qmul.sv
// Shared Q8.16 multiplier: round to nearest, saturate, registered result.
`default_nettype none
module mbts_qmul (
  input  wire logic          clk,
  input  mbts_pkg::q_t       a,
  input  mbts_pkg::q_t       b,
  output mbts_pkg::q_t       p_r
);
  logic signed [47:0] prod;
  logic signed [48:0] rnd;

  always_comb begin
    prod = a * b;
    rnd  = 49'(prod) + 49'sd32768;
  end

  always_ff @(posedge clk) begin
    p_r <= mbts_pkg::sat24(rnd >>> 16);
  end
endmodule
`default_nettype wire

// File: hw/rtl/mlp_backprop_train_step_unit.sv
// Top level: sequencer around the weight RAM, sigmoid ROM and shared multiplier.
// A training word is paced by the one multiplier and the single weight RAM port,
// and its prediction leaves before any weight moves. One word is in work at a
// time; a waiting result does not stop the next word from being taken, but holds
// back the result of that word. Synchronous reset makes all weights and biases
// read as zero and sets the rate to 0.1.
`default_nettype none
module mlp_backprop_train_step_unit #(
  parameter int HIDDEN_UNITS    = 2,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata,
  mbts_in_if.sink          in_ch,
  mbts_out_if.source       out_ch
);
  localparam int NW = 4 * HIDDEN_UNITS + 1;
  localparam int AW = $clog2(NW);
  localparam int JW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int IW = $clog2(SIGMOID_ENTRIES);
  localparam logic [AW-1:0] A_H  = AW'(HIDDEN_UNITS);
  localparam logic [AW-1:0] A_2H = AW'(2 * HIDDEN_UNITS);
  localparam logic [AW-1:0] A_3H = AW'(3 * HIDDEN_UNITS);
  localparam logic [AW-1:0] A_4H = AW'(4 * HIDDEN_UNITS);
  localparam logic [JW-1:0] J_LAST = JW'(HIDDEN_UNITS - 1);
  localparam mbts_pkg::q_t SIG_SPAN_C = mbts_pkg::SIG_SPAN;

  typedef enum logic [30:0] {
    S_IDLE    = 31'h1 << 0,  S_HB_RD  = 31'h1 << 1,  S_HB_LD  = 31'h1 << 2,
    S_HW_RD   = 31'h1 << 3,  S_HW_MUL = 31'h1 << 4,  S_HW_ACC = 31'h1 << 5,
    S_HSIG_RD = 31'h1 << 6,  S_HSIG   = 31'h1 << 7,  S_OB_RD  = 31'h1 << 8,
    S_OB_LD   = 31'h1 << 9,  S_OW_RD  = 31'h1 << 10, S_OW_MUL = 31'h1 << 11,
    S_OW_ACC  = 31'h1 << 12, S_OSIG_RD = 31'h1 << 13, S_OSIG  = 31'h1 << 14,
    S_DO_1    = 31'h1 << 15, S_DO_2   = 31'h1 << 16, S_DO_3   = 31'h1 << 17,
    S_DH_RD   = 31'h1 << 18, S_DH_1   = 31'h1 << 19, S_DH_2   = 31'h1 << 20,
    S_DH_3    = 31'h1 << 21, S_DH_4   = 31'h1 << 22, S_UP_RD  = 31'h1 << 23,
    S_UP_G    = 31'h1 << 24, S_UP_L   = 31'h1 << 25, S_UP_W   = 31'h1 << 26,
    S_WR      = 31'h1 << 27, S_RD_ISS = 31'h1 << 28, S_RD_DAT = 31'h1 << 29,
    S_POST    = 31'h1 << 30
  } state_t;

  state_t state_r, state_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          k_r, k_nxt;
  logic [AW-1:0] i_r, i_nxt;
  mbts_pkg::q_t  acc_r, acc_nxt, d_o_r, d_o_nxt, t_r, t_nxt;
  mbts_pkg::uq_t o_r, o_nxt;
  mbts_pkg::uq_t h_r [HIDDEN_UNITS];
  mbts_pkg::q_t  dh_r [HIDDEN_UNITS];
  logic          h_we, dh_we;
  mbts_pkg::q_t  x0_r, x1_r, wval_r;
  mbts_pkg::uq_t tgt_r;
  logic [3:0]    widx_r;
  logic [1:0]    kind_r;
  logic [16:0]   lr_r;
  logic [NW-1:0] vld_r;
  logic          rvld_r;
  logic          out_valid_r;
  mbts_pkg::uq_t out_pred_r;
  mbts_pkg::q_t  out_rb_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  mbts_pkg::q_t  mem_wdata, mem_rdata, rdata;
  mbts_pkg::q_t  mul_a, mul_b, p;
  logic [IW-1:0] rom_addr;
  mbts_pkg::uq_t rom_data;
  logic          in_fire, out_free, post;
  mbts_pkg::uq_t post_pred;
  mbts_pkg::q_t  post_rb;
  logic          widx_ok;
  logic [AW-1:0] widx_a;
  logic          up_hw, up_hb, up_ow, up_k;
  logic [AW-1:0] up_off;
  logic [JW-1:0] up_j;
  logic [19:0]   sig_off;
  logic [19+IW:0] sig_prod;

  mbts_ram #(.WIDTH(24), .DEPTH(NW)) u_wram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  mbts_sig_rom #(.ENTRIES(SIGMOID_ENTRIES)) u_rom (
    .clk(clk), .addr(rom_addr), .data_r(rom_data)
  );

  mbts_qmul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p));

  // Entries never written since reset read as zero.
  assign rdata   = rvld_r ? mem_rdata : '0;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.prediction = out_pred_r;
  assign out_ch.readback   = out_rb_r;

  assign widx_ok = (32'(widx_r) <= 32'(4 * HIDDEN_UNITS));
  assign widx_a  = AW'(32'(widx_r));

  // Index from the sigmoid argument, clamped at both ends of the table.
  always_comb begin
    sig_off  = 20'(acc_r + SIG_SPAN_C);
    sig_prod = (20 + IW)'(sig_off) * (20 + IW)'(SIGMOID_ENTRIES);
    if (acc_r < -mbts_pkg::SIG_SPAN) rom_addr = '0;
    else if (acc_r >= mbts_pkg::SIG_SPAN) rom_addr = IW'(SIGMOID_ENTRIES - 1);
    else rom_addr = sig_prod[19+IW:20];
  end

  // Decode of the weight index swept during the update pass.
  always_comb begin
    up_hw = (i_r < A_2H);
    up_hb = !up_hw && (i_r < A_3H);
    up_ow = !up_hw && !up_hb && (i_r < A_4H);
    up_k  = (i_r >= A_H);
    if (up_hw) up_off = up_k ? i_r - A_H : i_r;
    else if (up_hb) up_off = i_r - A_2H;
    else up_off = i_r - A_3H;
    up_j = up_off[JW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    k_nxt = k_r;
    i_nxt = i_r;
    acc_nxt = acc_r;
    o_nxt = o_r;
    d_o_nxt = d_o_r;
    t_nxt = t_r;
    h_we = 1'b0;
    dh_we = 1'b0;
    mem_we = 1'b0;
    mem_waddr = i_r;
    mem_wdata = mbts_pkg::sat24(49'(rdata) + 49'(p));
    mem_raddr = '0;
    mul_a = '0;
    mul_b = '0;
    post = 1'b0;
    post_pred = '0;
    post_rb = '0;
    case (state_r)
      S_IDLE: begin
        j_nxt = '0;
        k_nxt = 1'b0;
        i_nxt = '0;
        if (in_fire) begin
          case (in_ch.kind)
            mbts_pkg::KIND_TRAIN: state_nxt = S_HB_RD;
            mbts_pkg::KIND_WRITE: state_nxt = S_WR;
            mbts_pkg::KIND_READ:  state_nxt = S_RD_ISS;
            default:              state_nxt = S_POST;
          endcase
        end
      end
      S_HB_RD: begin
        mem_raddr = A_2H + AW'(j_r);
        state_nxt = S_HB_LD;
      end
      S_HB_LD: begin
        acc_nxt = rdata;
        k_nxt = 1'b0;
        state_nxt = S_HW_RD;
      end
      S_HW_RD: begin
        mem_raddr = (k_r ? A_H : '0) + AW'(j_r);
        state_nxt = S_HW_MUL;
      end
      S_HW_MUL: begin
        mul_a = k_r ? x1_r : x0_r;
        mul_b = rdata;
        state_nxt = S_HW_ACC;
      end
      S_HW_ACC: begin
        acc_nxt = mbts_pkg::sat24(49'(acc_r) + 49'(p));
        k_nxt = 1'b1;
        state_nxt = k_r ? S_HSIG_RD : S_HW_RD;
      end
      S_HSIG_RD: state_nxt = S_HSIG;
      S_HSIG: begin
        h_we = 1'b1;
        if (j_r == J_LAST) begin
          j_nxt = '0;
          state_nxt = S_OB_RD;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_HB_RD;
        end
      end
      S_OB_RD: begin
        mem_raddr = A_4H;
        state_nxt = S_OB_LD;
      end
      S_OB_LD: begin
        acc_nxt = rdata;
        state_nxt = S_OW_RD;
      end
      S_OW_RD: begin
        mem_raddr = A_3H + AW'(j_r);
        state_nxt = S_OW_MUL;
      end
      S_OW_MUL: begin
        mul_a = 24'(h_r[j_r]);
        mul_b = rdata;
        state_nxt = S_OW_ACC;
      end
      S_OW_ACC: begin
        acc_nxt = mbts_pkg::sat24(49'(acc_r) + 49'(p));
        if (j_r == J_LAST) begin
          j_nxt = '0;
          state_nxt = S_OSIG_RD;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_OW_RD;
        end
      end
      S_OSIG_RD: state_nxt = S_OSIG;
      S_OSIG: begin
        // The prediction goes out before any weight moves.
        post = 1'b1;
        post_pred = rom_data;
        o_nxt = rom_data;
        if (out_free) state_nxt = S_DO_1;
      end
      S_DO_1: begin
        mul_a = 24'(o_r);
        mul_b = mbts_pkg::Q_ONE - 24'(o_r);
        state_nxt = S_DO_2;
      end
      S_DO_2: begin
        mul_a = 24'(tgt_r) - 24'(o_r);
        mul_b = p;
        state_nxt = S_DO_3;
      end
      S_DO_3: begin
        d_o_nxt = p;
        j_nxt = '0;
        state_nxt = S_DH_RD;
      end
      S_DH_RD: begin
        mem_raddr = A_3H + AW'(j_r);
        state_nxt = S_DH_1;
      end
      S_DH_1: begin
        mul_a = d_o_r;
        mul_b = rdata;
        state_nxt = S_DH_2;
      end
      S_DH_2: begin
        t_nxt = p;
        mul_a = 24'(h_r[j_r]);
        mul_b = mbts_pkg::Q_ONE - 24'(h_r[j_r]);
        state_nxt = S_DH_3;
      end
      S_DH_3: begin
        mul_a = t_r;
        mul_b = p;
        state_nxt = S_DH_4;
      end
      S_DH_4: begin
        dh_we = 1'b1;
        if (j_r == J_LAST) begin
          i_nxt = '0;
          state_nxt = S_UP_RD;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_DH_RD;
        end
      end
      S_UP_RD: begin
        mem_raddr = i_r;
        state_nxt = S_UP_G;
      end
      S_UP_G: begin
        // Bias gradients pass through the multiplier as a product with one.
        mem_raddr = i_r;
        if (up_hw) begin
          mul_a = up_k ? x1_r : x0_r;
          mul_b = dh_r[up_j];
        end else if (up_hb) begin
          mul_a = dh_r[up_j];
          mul_b = mbts_pkg::Q_ONE;
        end else if (up_ow) begin
          mul_a = 24'(h_r[up_j]);
          mul_b = d_o_r;
        end else begin
          mul_a = d_o_r;
          mul_b = mbts_pkg::Q_ONE;
        end
        state_nxt = S_UP_L;
      end
      S_UP_L: begin
        mem_raddr = i_r;
        mul_a = p;
        mul_b = 24'(lr_r);
        state_nxt = S_UP_W;
      end
      S_UP_W: begin
        mem_raddr = i_r;
        mem_we = 1'b1;
        if (i_r == A_4H) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_UP_RD;
        end
      end
      S_WR: begin
        mem_we = widx_ok;
        mem_waddr = widx_a;
        mem_wdata = wval_r;
        state_nxt = S_POST;
      end
      S_RD_ISS: begin
        mem_raddr = widx_a;
        state_nxt = S_RD_DAT;
      end
      S_RD_DAT: begin
        mem_raddr = widx_a;
        post = 1'b1;
        post_rb = widx_ok ? rdata : '0;
        if (out_free) state_nxt = S_IDLE;
      end
      S_POST: begin
        post = 1'b1;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      rvld_r <= 1'b0;
      out_valid_r <= 1'b0;
      lr_r <= 17'd6554;
    end else begin
      state_r <= state_nxt;
      if (mem_we) vld_r[mem_waddr] <= 1'b1;
      rvld_r <= vld_r[mem_raddr];
      if (cfg_we) lr_r <= cfg_wdata;
      if (post && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    k_r <= k_nxt;
    i_r <= i_nxt;
    acc_r <= acc_nxt;
    o_r <= o_nxt;
    d_o_r <= d_o_nxt;
    t_r <= t_nxt;
    if (h_we) h_r[j_r] <= rom_data;
    if (dh_we) dh_r[j_r] <= p;
    if (in_fire) begin
      kind_r <= in_ch.kind;
      x0_r <= in_ch.feature_a;
      x1_r <= in_ch.feature_b;
      tgt_r <= in_ch.target;
      widx_r <= in_ch.weight_index;
      wval_r <= in_ch.weight_value;
    end
    if (post && out_free) begin
      out_pred_r <= post_pred;
      out_rb_r <= post_rb;
    end
  end

  a_train_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.kind == mbts_pkg::KIND_TRAIN |=> state_r == S_HB_RD)
    else $error("training word did not start the forward pass");
  a_write_place: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WR || state_r == S_UP_W) && mem_waddr <= A_4H)
    else $error("weight RAM written outside a load or update");
  a_post_room: assert property (@(posedge clk) disable iff (!rst_n)
    post && state_r != state_nxt |-> out_free)
    else $error("result posted over a waiting word");
  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> $stable(kind_r))
    else $error("request captured while busy");

endmodule
`default_nettype wire
